/* rtl/core/stcf_pkg.sv */
// Shared types and codes for the slice scheduler: beat payloads, status codes,
// controller command and datapath status groups. No dependencies.
`default_nettype none

package stcf_pkg;

  localparam int DEF_MAX_JOBS = 16;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [31:0] arrival_time;
    logic [15:0] job_length;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  job_number;
    logic [31:0] start_time;
    logic [15:0] ran_for;
    logic        job_finished;
  } result_t;

  typedef struct packed {
    logic accept;
    logic scan_rd;
    logic commit_add;
    logic commit_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

/* rtl/core/stcf_ctrl.sv */
// Controller state machine for the slice scheduler.
// Depends on stcf_pkg for the command and status groups.
`default_nettype none

module stcf_ctrl
  import stcf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  input  wire logic       item_kind,
  output logic            item_ready,
  input  wire dp_status_t st,
  output ctrl_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_ADD    = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.accept = 1'b1;
          state_next = (item_kind == KIND_ADD) ? S_ADD : S_SCAN;
        end
      end
      S_SCAN: begin
        // the beat read in the previous cycle is compared in this one
        if (st.scan_done) begin
          state_next = S_DECIDE;
        end else begin
          cmd.scan_rd = 1'b1;
        end
      end
      S_DECIDE: begin
        if (st.out_free) begin
          cmd.commit_step = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_ADD: begin
        if (st.out_free) begin
          cmd.commit_add = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/stcf_dpath.sv */
// Datapath for the slice scheduler: job tables, scan compare, time and output register.
// Depends on stcf_pkg for payload types, status codes and control groups.
`default_nettype none

module stcf_dpath
  import stcf_pkg::*;
#(
  parameter int MAX_JOBS = DEF_MAX_JOBS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ctrl_cmd_t   cmd,
  output dp_status_t       st,
  input  wire item_t       item,
  input  wire logic        cfg_valid,
  input  wire logic [15:0] cfg_data,
  output result_t          result,
  output logic             result_valid,
  input  wire logic        result_ready
);

  localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W = $clog2(MAX_JOBS + 1);

  logic [31:0] arr_mem [MAX_JOBS];
  logic [15:0] rem_mem [MAX_JOBS];

  item_t            held;
  logic [CNT_W-1:0] job_count;
  logic [31:0]      cur_time;
  logic [15:0]      slice_length;
  logic [CNT_W-1:0] scan_idx;
  logic             rd_valid;
  logic [IDX_W-1:0] rd_idx;
  logic [31:0]      rd_arr;
  logic [15:0]      rd_rem;
  logic             have_best;
  logic             any_left;
  logic [IDX_W-1:0] best_idx;
  logic [15:0]      best_rem;

  logic             full;
  logic [15:0]      slice_eff;
  logic [15:0]      run;
  logic [15:0]      rem_after;
  logic [15:0]      step_amount;
  logic [32:0]      time_sum;
  logic [31:0]      time_next;
  logic             better;
  logic [IDX_W+3:0] best_ext;
  logic [CNT_W+3:0] cnt_ext;
  logic [IDX_W-1:0] wr_idx;

  assign full        = (job_count == CNT_W'(MAX_JOBS));
  assign slice_eff   = (slice_length == 16'd0) ? 16'd1 : slice_length;
  assign run         = (best_rem < slice_eff) ? best_rem : slice_eff;
  assign rem_after   = best_rem - run;
  assign step_amount = have_best ? run : slice_eff;
  assign time_sum    = {1'b0, cur_time} + {17'd0, step_amount};
  assign time_next   = time_sum[32] ? 32'hFFFF_FFFF : time_sum[31:0];
  assign better      = (rd_rem != 16'd0) && (rd_arr <= cur_time) &&
                       (!have_best || (rd_rem < best_rem));
  assign best_ext    = {4'd0, best_idx};
  assign cnt_ext     = {4'd0, job_count};
  assign wr_idx      = job_count[IDX_W-1:0];

  assign st.scan_done = (scan_idx == job_count);
  assign st.out_free  = !result_valid || result_ready;

  // Tables: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.commit_add && !full) begin
      arr_mem[wr_idx] <= held.arrival_time;
      rem_mem[wr_idx] <= held.job_length;
    end else if (cmd.commit_step && have_best) begin
      rem_mem[best_idx] <= rem_after;
    end
    if (cmd.scan_rd) begin
      rd_arr <= arr_mem[scan_idx[IDX_W-1:0]];
      rd_rem <= rem_mem[scan_idx[IDX_W-1:0]];
      rd_idx <= scan_idx[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      held <= item;
    end
    if (rd_valid && better) begin
      best_idx <= rd_idx;
      best_rem <= rd_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_count    <= '0;
      cur_time     <= '0;
      slice_length <= 16'd1;
      scan_idx     <= '0;
      rd_valid     <= 1'b0;
      have_best    <= 1'b0;
      any_left     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        slice_length <= cfg_data;
      end
      rd_valid <= cmd.scan_rd;
      if (cmd.accept) begin
        scan_idx  <= '0;
        have_best <= 1'b0;
        any_left  <= 1'b0;
      end else begin
        if (cmd.scan_rd) begin
          scan_idx <= scan_idx + 1'b1;
        end
        if (rd_valid) begin
          if (rd_rem != 16'd0) begin
            any_left <= 1'b1;
          end
          if (better) begin
            have_best <= 1'b1;
          end
        end
      end
      if (cmd.commit_add && !full) begin
        job_count <= job_count + 1'b1;
      end
      if (cmd.commit_step && any_left) begin
        cur_time <= time_next;
      end
      if (cmd.commit_add || cmd.commit_step) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit_add) begin
      result.start_time   <= cur_time;
      result.ran_for      <= 16'd0;
      result.job_finished <= 1'b0;
      if (full) begin
        result.status     <= ST_FULL;
        result.job_number <= 4'd0;
      end else begin
        result.status     <= ST_OK;
        result.job_number <= cnt_ext[3:0];
      end
    end else if (cmd.commit_step) begin
      result.start_time <= cur_time;
      if (!any_left) begin
        result.status       <= ST_DONE;
        result.job_number   <= 4'd0;
        result.ran_for      <= 16'd0;
        result.job_finished <= 1'b0;
      end else if (!have_best) begin
        result.status       <= ST_IDLE;
        result.job_number   <= 4'd0;
        result.ran_for      <= 16'd0;
        result.job_finished <= 1'b0;
      end else begin
        result.status       <= ST_OK;
        result.job_number   <= best_ext[3:0];
        result.ran_for      <= run;
        result.job_finished <= (rem_after == 16'd0);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/stcf_slice_scheduler_top.sv */
// Top level of the shortest-remaining-time-first slice scheduler.
// Depends on stcf_pkg, stcf_ctrl and stcf_dpath.
//
// Usage:
//   item channel   : one beat per job add (kind 0) or scheduling step (kind 1).
//   result channel : exactly one beat per item, in item order.
//   cfg channel    : writes slice_length; always ready. Write it only while idle.
// Sequencing:
//   an add goes through the add state and then commits to the result register.
//   a step scans the job table through one memory read port, one entry a
//   cycle, then decides and commits to the result register.
//   One item is worked on at a time; item_ready is high in the idle state.
// Stall behaviour:
//   the result register holds a finished beat while result_ready is low; the
//   next item is still accepted and worked on, and waits at its commit point
//   until the register frees up. Nothing is dropped.
// Reset:
//   synchronous rst clears the job count, the current time, the pending
//   result and sets slice_length to 1. The job tables are not cleared; only
//   loaded entries are ever read.
`default_nettype none

module stcf_slice_scheduler_top
  import stcf_pkg::*;
#(
  parameter int MAX_JOBS = DEF_MAX_JOBS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire item_t       item,
  output logic             result_valid,
  input  wire logic        result_ready,
  output result_t          result,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  // Configuration writes go straight into a register, so never stall them
  assign cfg_ready = 1'b1;

  stcf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_kind  (item.kind),
    .item_ready (item_ready),
    .st         (st),
    .cmd        (cmd)
  );

  stcf_dpath #(
    .MAX_JOBS (MAX_JOBS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .item         (item),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

endmodule

`default_nettype wire

/* rtl/core/stcf_checker.sv */
// Port-level checks for the slice scheduler, bound to the top level.
// Depends on stcf_pkg for the payload types and status codes.
`default_nettype none

module stcf_checker
  import stcf_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        item_valid,
  input wire logic        item_ready,
  input wire logic        result_valid,
  input wire logic        result_ready,
  input wire result_t     result
);

  // hold a stalled result beat
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // one item in flight: drop ready after an accepted beat
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item accepted while another is in flight");

  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != ST_OK |->
      result.ran_for == 16'd0 && result.job_finished == 1'b0 &&
      result.job_number == 4'd0)
    else $error("idle, done or full beat carries run fields");

  a_finish_ran: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.job_finished |->
      result.status == ST_OK && result.ran_for != 16'd0)
    else $error("job finished without running");

endmodule

bind stcf_slice_scheduler_top stcf_checker u_stcf_checker (.*);

`default_nettype wire

/* tb/sv/stcf_slice_scheduler_top_tb.sv */
// Self-checking testbench for stcf_slice_scheduler_top: drives job adds and scheduling
// steps, predicts every result beat in-bench and compares them field by field.
// Depends on stcf_pkg and the scheduler RTL only.
`timescale 1ns / 1ps

module stcf_slice_scheduler_top_tb;
  import stcf_pkg::*;

  localparam int          MAX_JOBS     = DEF_MAX_JOBS;
  localparam int          CYCLE_LIMIT  = 4_000_000;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          HOLD_CYCLES  = 400;
  localparam logic [31:0] TIME_TOP     = 32'hFFFF_FFFF;

  // Idling modes, one per phase
  localparam int MODE_BUSY       = 0;
  localparam int MODE_SEND_GAPS  = 1;
  localparam int MODE_RECV_STALL = 2;
  localparam int MODE_BOTH       = 3;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_ready;
  item_t       item;
  logic        result_valid;
  logic        result_ready;
  result_t     result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  // Scheduler state as the bench sees it
  logic [31:0] arrival_tbl   [MAX_JOBS];
  logic [15:0] remaining_tbl [MAX_JOBS];
  int unsigned jobs_loaded;
  logic [31:0] sched_time;
  logic [15:0] slice_reg;

  result_t     awaited_results [$];
  item_t       outgoing_items  [$];
  result_t     head_result;
  bit          item_took;
  int unsigned items_queued;
  int unsigned items_accepted;
  int unsigned results_seen;
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned status_seen [4];
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned hold_left;

  stcf_slice_scheduler_top #(
    .MAX_JOBS(MAX_JOBS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Add with saturation at the top of the time range
  function automatic logic [31:0] time_after(logic [31:0] base, logic [31:0] amount);
    logic [32:0] total;
    total = {1'b0, base} + {1'b0, amount};
    return total[32] ? TIME_TOP : total[31:0];
  endfunction

  // Apply one accepted item to the bench state and return the beat it must produce
  function automatic result_t schedule_item(item_t it);
    result_t     res;
    int          pick;
    bit          found;
    bit          work_left;
    logic [31:0] slice_eff;
    logic [31:0] granted;
    res            = '0;
    res.start_time = sched_time;
    // a zero slice behaves as a slice of one
    slice_eff      = (slice_reg == 16'd0) ? 32'd1 : {16'd0, slice_reg};
    if (it.kind == KIND_ADD) begin
      if (jobs_loaded >= MAX_JOBS) begin
        res.status = ST_FULL;
      end else begin
        arrival_tbl[jobs_loaded]   = it.arrival_time;
        remaining_tbl[jobs_loaded] = it.job_length;
        res.status                 = ST_OK;
        res.job_number             = 4'(jobs_loaded);
        jobs_loaded++;
      end
      return res;
    end
    pick      = 0;
    found     = 1'b0;
    work_left = 1'b0;
    // Strict less-than keeps ties on the earliest loaded job
    for (int j = 0; j < jobs_loaded; j++) begin
      if (remaining_tbl[j] != 16'd0) begin
        work_left = 1'b1;
        if (arrival_tbl[j] <= sched_time &&
            (!found || remaining_tbl[j] < remaining_tbl[pick])) begin
          pick  = j;
          found = 1'b1;
        end
      end
    end
    if (!work_left) begin
      res.status = ST_DONE;
    end else if (!found) begin
      res.status = ST_IDLE;
      sched_time = time_after(sched_time, slice_eff);
    end else begin
      granted             = ({16'd0, remaining_tbl[pick]} < slice_eff) ?
                            {16'd0, remaining_tbl[pick]} : slice_eff;
      remaining_tbl[pick] = remaining_tbl[pick] - granted[15:0];
      sched_time          = time_after(sched_time, granted);
      res.status          = ST_OK;
      res.job_number      = 4'(pick);
      res.ran_for         = granted[15:0];
      res.job_finished    = (remaining_tbl[pick] == 16'd0);
    end
    return res;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      fail_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Rising edge: record accepted items, check result beats
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count++;
    if (!rst && item_valid && item_ready) begin
      awaited_results.push_back(schedule_item(item));
      items_accepted++;
      item_took = 1'b1;
    end
    if (!rst && result_valid && result_ready) begin
      results_seen++;
      status_seen[result.status]++;
      if (awaited_results.size() == 0) begin
        $error("result beat with nothing awaited: status %0d, job %0d",
               result.status, result.job_number);
        fail_count++;
      end else begin
        head_result = awaited_results.pop_front();
        check_field("status",       head_result.status,       result.status);
        check_field("job_number",   head_result.job_number,   result.job_number);
        check_field("start_time",   head_result.start_time,   result.start_time);
        check_field("ran_for",      head_result.ran_for,      result.ran_for);
        check_field("job_finished", head_result.job_finished, result.job_finished);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Falling edge: item driver. Hold the beat until it is taken, then either
  // present the next queued item or drop valid for a gap.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!item_valid || item_took) begin
      item_took = 1'b0;
      if (outgoing_items.size() != 0 && $urandom_range(99) >= gap_pct) begin
        item       <= outgoing_items.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Result side: a counted hold-off wins over the random stalls
  always @(negedge clk) begin
    if (hold_left != 0) begin
      result_ready <= 1'b0;
      hold_left--;
    end else begin
      result_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Queue one item and return once the block has taken it
  task automatic send_item(item_t it);
    int unsigned ticket;
    items_queued++;
    ticket = items_queued;
    outgoing_items.push_back(it);
    wait (items_accepted >= ticket);
  endtask

  // Pause the sender until every awaited beat has come back
  task automatic wait_idle();
    while (items_accepted != items_queued || awaited_results.size() != 0)
      @(posedge clk);
  endtask

  // Write slice_length; only ever called with the block idle
  task automatic write_slice(logic [15:0] value);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    slice_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(int mode);
    case (mode)
      MODE_BUSY: begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      MODE_SEND_GAPS: begin
        gap_pct   = 59;
        stall_pct = 0;
      end
      MODE_RECV_STALL: begin
        gap_pct   = 0;
        stall_pct = 59;
      end
      default: begin
        gap_pct   = 38;
        stall_pct = 38;
      end
    endcase
  endtask

  function automatic item_t add_item(logic [31:0] arrival, logic [15:0] length);
    item_t it;
    it.kind         = KIND_ADD;
    it.arrival_time = arrival;
    it.job_length   = length;
    return it;
  endfunction

  // Steps ignore the payload, so fill it with noise
  function automatic item_t step_item();
    item_t it;
    it.kind         = KIND_STEP;
    it.arrival_time = $urandom;
    it.job_length   = 16'($urandom);
    return it;
  endfunction

  // Early phases: few adds, arrivals close to the current time so jobs
  // overlap, short lengths so jobs come and go
  function automatic item_t arrival_mix_item(int unsigned job_cap);
    logic [31:0] arrival;
    logic [15:0] length;
    if ($urandom_range(99) < 15 && jobs_loaded < job_cap) begin
      if ($urandom_range(99) < 20)
        arrival = $urandom;
      else
        arrival = time_after(sched_time, $urandom_range(0, 120));
      length = ($urandom_range(99) < 10) ? 16'd0 : 16'($urandom_range(1, 60));
      return add_item(arrival, length);
    end
    return step_item();
  endfunction

  // Late phases: arrivals anywhere in the time range; fill the table and go on adding
  function automatic item_t full_table_item();
    logic [15:0] length;
    int unsigned roll;
    if ($urandom_range(99) < 25) begin
      roll = $urandom_range(99);
      if (roll < 10)
        length = 16'd0;
      else if (roll < 20)
        length = 16'hFFFF;
      else
        length = 16'($urandom_range(1, 30));
      return add_item($urandom, length);
    end
    return step_item();
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty table, zero length, idling, zero slice, ties, extreme lengths
  task automatic test_directed_cases();
    set_idling(MODE_BUSY);
    send_item(step_item());                     // empty table: all done
    send_item(add_item(32'd0, 16'd0));          // job stored already finished
    send_item(step_item());                     // only a finished job: all done
    send_item(add_item(32'd5, 16'd3));
    send_item(step_item());                     // nothing arrived: idle one slice
    write_slice(16'd0);
    send_item(step_item());                     // zero slice advances by one
    write_slice(16'd4);
    send_item(step_item());
    send_item(step_item());                     // short job runs what remains
    send_item(add_item(32'd0, 16'hFFFF));
    send_item(add_item(32'd0, 16'hFFFF));
    send_item(step_item());                     // tie goes to the earlier job
    send_item(step_item());
    write_slice(16'hFFFF);
    send_item(step_item());
    send_item(step_item());                     // full slice of 65535
    // Arrives only once time reaches the top, so it keeps the table busy
    send_item(add_item(TIME_TOP, 16'd1));
    send_item(step_item());
    send_item(step_item());
    wait_idle();
  endtask

  // Hold the result side off while the sender keeps offering beats
  task automatic test_result_backpressure();
    write_slice(16'd3);
    set_idling(MODE_BUSY);
    hold_left = HOLD_CYCLES;
    send_item(add_item(sched_time, 16'd7));
    repeat (5) send_item(step_item());
    wait_idle();
  endtask

  task automatic test_arrival_phases();
    logic [15:0] slices [4];
    slices[0] = 16'd1;
    slices[1] = 16'd0;
    slices[2] = 16'd9;
    slices[3] = 16'($urandom_range(2, 300));
    for (int p = 0; p < 4; p++) begin
      write_slice(slices[p]);
      set_idling(p);
      repeat (100) send_item(arrival_mix_item(7));
    end
    wait_idle();
  endtask

  task automatic test_full_table_phases();
    logic [15:0] slices [4];
    slices[0] = 16'hFFFF;
    slices[1] = 16'd1;
    slices[2] = 16'd5;
    slices[3] = 16'($urandom_range(1, 65535));
    for (int p = 0; p < 4; p++) begin
      write_slice(slices[p]);
      set_idling(MODE_BOTH - p);
      repeat (110) send_item(full_table_item());
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst            = 1'b1;
    item_valid     = 1'b0;
    item           = '0;
    result_ready   = 1'b0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    item_took      = 1'b0;
    items_queued   = 0;
    items_accepted = 0;
    results_seen   = 0;
    fail_count     = 0;
    cycle_count    = 0;
    gap_pct        = 0;
    stall_pct      = 0;
    hold_left      = 0;
    jobs_loaded    = 0;
    sched_time     = '0;
    slice_reg      = 16'd1;
    for (int s = 0; s < 4; s++) status_seen[s] = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_result_backpressure();
    test_arrival_phases();
    test_full_table_phases();

    // Let any stray beat show up before judging
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0) begin
      $error("%0d result beats never arrived", awaited_results.size());
      fail_count++;
    end

    $display("Ran %0d items to %0d results: %0d ran/added, %0d idle, %0d all done, %0d full",
             items_accepted, results_seen, status_seen[ST_OK], status_seen[ST_IDLE],
             status_seen[ST_DONE], status_seen[ST_FULL]);
    $display("Jobs loaded %0d, final time %0h, %0d mismatches", jobs_loaded, sched_time,
             fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
